[hw/rtl/mtrd_pkg.sv]
// Shared types and constants for the Modbus TCP response decoder.
package mtrd_pkg;

  // Widths of the stream fields
  localparam int unsigned ByteW    = 8;
  localparam int unsigned QtyW     = 11;
  localparam int unsigned PosW     = 17;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 64;

  // Saturation value of the frame byte position
  localparam logic [PosW-1:0] PosMax = '1;

  // Frame byte offsets of the MBAP header and PDU
  localparam logic [PosW-1:0] PosTxnHi   = 17'd0;
  localparam logic [PosW-1:0] PosTxnLo   = 17'd1;
  localparam logic [PosW-1:0] PosLenHi   = 17'd4;
  localparam logic [PosW-1:0] PosLenLo   = 17'd5;
  localparam logic [PosW-1:0] PosUnit    = 17'd6;
  localparam logic [PosW-1:0] PosFunc    = 17'd7;
  localparam logic [PosW-1:0] PosCount   = 17'd8;
  localparam logic [PosW-1:0] PosData    = 17'd9;

  // Output FIFO depth, and the fill level at which two more entries still fit
  localparam int unsigned          FifoDepth = 4;
  localparam int unsigned          FifoPtrW  = $clog2(FifoDepth);
  localparam logic [FifoPtrW:0]    FifoRoom2 = (FifoPtrW+1)'(FifoDepth - 2);

  typedef enum logic {
    MODE_REGS = 1'b0,
    MODE_BITS = 1'b1
  } mtrd_mode_e;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } mtrd_kind_e;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_SHORT_FRAME    = 3'd1,
    ST_BAD_LENGTH     = 3'd2,
    ST_EXCEPTION      = 3'd3,
    ST_SHORT_RESPONSE = 3'd4,
    ST_COUNT_MISMATCH = 3'd5
  } mtrd_status_e;

  // One result item
  typedef struct packed {
    mtrd_kind_e   item_kind;
    logic         last_of_run;
    logic         exception_present;
    logic [7:0]   exception_code;
    logic [7:0]   unit_id;
    logic [15:0]  txn_id;
    mtrd_status_e status;
    logic [4:0]   valid_bits;
    logic [15:0]  data_value;
  } mtrd_result_t;

  // Results caused by one input byte, in order r0 then r1
  typedef struct packed {
    logic [1:0]   cnt;
    mtrd_result_t r0;
    mtrd_result_t r1;
  } mtrd_push_t;

endpackage

[hw/rtl/mtrd_parser.sv]
// Frame parser: byte position, header hold registers and result decode.
module mtrd_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [mtrd_pkg::ByteW-1:0]  rx_byte_i,
  input  logic                        frame_last_i,
  input  logic                        decode_mode_i,
  input  logic [mtrd_pkg::QtyW-1:0]   expected_quantity_i,
  output mtrd_pkg::mtrd_push_t        push_o
);
  import mtrd_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     txn_q, txn_d;
  logic [15:0]     len_q, len_d;
  logic [7:0]      unit_q, unit_d;
  logic            exc_q, exc_d;
  logic [7:0]      bc_q, bc_d;
  logic [7:0]      hi_q, hi_d;
  logic            mode_q, mode_d;
  logic [QtyW-1:0] qty_q, qty_d;

  logic            first;
  logic [PosW-1:0] k;
  logic            have_data;
  mtrd_result_t    data_r, stat_r;
  logic [13:0]     bit_base, bit_rem;
  logic [3:0]      vb_bits;
  logic [7:0]      bit_mask;
  logic [PosW:0]   size;
  mtrd_status_e    st;

  // Header capture and data decode for the byte in the input register
  always_comb begin
    first  = (pos_q == '0);
    txn_d  = first ? '0 : txn_q;
    len_d  = first ? '0 : len_q;
    unit_d = first ? '0 : unit_q;
    exc_d  = first ? 1'b0 : exc_q;
    bc_d   = first ? '0 : bc_q;
    hi_d   = first ? '0 : hi_q;
    mode_d = first ? decode_mode_i : mode_q;
    qty_d  = first ? expected_quantity_i : qty_q;

    case (pos_q)
      PosTxnHi: txn_d  = {rx_byte_i, txn_d[7:0]};
      PosTxnLo: txn_d  = {txn_d[15:8], rx_byte_i};
      PosLenHi: len_d  = {rx_byte_i, len_d[7:0]};
      PosLenLo: len_d  = {len_d[15:8], rx_byte_i};
      PosUnit:  unit_d = rx_byte_i;
      PosFunc:  exc_d  = rx_byte_i[7];
      PosCount: bc_d   = rx_byte_i;
      default:  ;
    endcase

    // Data bytes: register words big-endian, or up to eight bits per byte
    k         = pos_q - PosData;
    have_data = 1'b0;
    bit_base  = {k[10:0], 3'b000};
    bit_rem   = {3'b000, qty_q} - bit_base;
    vb_bits   = (bit_rem > 14'd8) ? 4'd8 : bit_rem[3:0];
    bit_mask  = 8'hFF >> (4'd8 - vb_bits);

    data_r                   = '0;
    data_r.item_kind         = KIND_DATA;
    data_r.status            = ST_OK;
    data_r.txn_id            = txn_q;
    data_r.unit_id           = unit_q;

    if (pos_q >= PosData && !exc_q) begin
      if (mode_q == MODE_REGS) begin
        if (!k[0]) begin
          hi_d = rx_byte_i;
        end else if (k[PosW-1:1] < {5'b0, qty_q}) begin
          have_data         = 1'b1;
          data_r.data_value = {hi_q, rx_byte_i};
          data_r.valid_bits = 5'd16;
        end
      end else if (k < 17'h800 && bit_base < {3'b000, qty_q}) begin
        have_data         = 1'b1;
        data_r.data_value = {8'h00, rx_byte_i & bit_mask};
        data_r.valid_bits = {1'b0, vb_bits};
      end
    end

    // Frame checks at the last byte, on the header as it stands after this byte
    size = {1'b0, pos_q} + 18'd1;
    if (pos_q < PosFunc) begin
      st = ST_SHORT_FRAME;
    end else if (len_d < 16'd2 || (18'd6 + {2'b00, len_d}) != size) begin
      st = ST_BAD_LENGTH;
    end else if (exc_d) begin
      st = ST_EXCEPTION;
    end else if (len_d < 16'd3) begin
      st = ST_SHORT_RESPONSE;
    end else if ({1'b0, len_d} < (17'd3 + {9'b0, bc_d})) begin
      st = ST_COUNT_MISMATCH;
    end else if (mode_d == MODE_REGS) begin
      st = ({4'b0000, bc_d} != {qty_d, 1'b0}) ? ST_COUNT_MISMATCH : ST_OK;
    end else begin
      st = ({bc_d, 3'b000} < qty_d) ? ST_COUNT_MISMATCH : ST_OK;
    end

    stat_r             = '0;
    stat_r.item_kind   = KIND_STATUS;
    stat_r.status      = st;
    stat_r.last_of_run = 1'b1;
    if (st != ST_SHORT_FRAME && st != ST_BAD_LENGTH) begin
      stat_r.txn_id  = txn_d;
      stat_r.unit_id = unit_d;
    end
    if (st == ST_EXCEPTION && len_d > 16'd2) begin
      stat_r.exception_code    = bc_d;
      stat_r.exception_present = 1'b1;
    end

    // Order the results: a data item always precedes the status item
    push_o    = '0;
    push_o.r0 = data_r;
    push_o.r1 = stat_r;
    if (valid_i) begin
      if (have_data && frame_last_i) begin
        push_o.cnt = 2'd2;
      end else if (have_data) begin
        push_o.cnt            = 2'd1;
        push_o.r0.last_of_run = 1'b1;
      end else if (frame_last_i) begin
        push_o.cnt = 2'd1;
        push_o.r0  = stat_r;
      end
    end

    // Position advances, saturates on overlong frames, clears after the last byte
    if (frame_last_i) begin
      pos_d = '0;
    end else begin
      pos_d = (pos_q == PosMax) ? PosMax : pos_q + 17'd1;
    end
  end

  // Frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      txn_q  <= '0;
      len_q  <= '0;
      unit_q <= '0;
      exc_q  <= 1'b0;
      bc_q   <= '0;
      hi_q   <= '0;
      mode_q <= 1'b0;
      qty_q  <= '0;
    end else if (valid_i) begin
      pos_q  <= pos_d;
      txn_q  <= txn_d;
      len_q  <= len_d;
      unit_q <= unit_d;
      exc_q  <= exc_d;
      bc_q   <= bc_d;
      hi_q   <= hi_d;
      mode_q <= mode_d;
      qty_q  <= qty_d;
    end
  end

  // The last byte of a frame always returns the position to the start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && frame_last_i |=> pos_q == '0)
    else $error("byte position not cleared after last byte");

  // Two results only when the second one is the status item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.cnt == 2'd2 |-> push_o.r0.item_kind == KIND_DATA
                           && push_o.r1.item_kind == KIND_STATUS)
    else $error("bad result ordering");

endmodule

[hw/rtl/mtrd_out_fifo.sv]
// Result FIFO: takes up to two results a cycle, hands out one a cycle while the reader is ready.
module mtrd_out_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mtrd_pkg::mtrd_push_t   push_i,
  output logic                   room2_o,
  output logic                   valid_o,
  input  logic                   ready_i,
  output mtrd_pkg::mtrd_result_t data_o
);
  import mtrd_pkg::*;

  mtrd_result_t        mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FifoPtrW:0]   cnt_q, cnt_d;
  logic                pop;
  logic [FifoPtrW-1:0] wr_next;

  always_comb begin
    pop     = valid_o && ready_i;
    wr_next = wr_q + 1'b1;
    wr_d    = wr_q + FifoPtrW'(push_i.cnt);
    rd_d    = rd_q + FifoPtrW'(pop);
    cnt_d   = cnt_q + (FifoPtrW+1)'(push_i.cnt) - (FifoPtrW+1)'(pop);
  end

  assign valid_o = (cnt_q != '0);
  assign room2_o = (cnt_q <= FifoRoom2);
  assign data_o  = mem_q[rd_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_next] <= push_i.r1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Writes only arrive when both entries fit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd0 |-> room2_o)
    else $error("result FIFO overflow");

  // Fill count stays within the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (FifoPtrW+1)'(FifoDepth))
    else $error("result FIFO count out of range");

endmodule

[hw/rtl/modbus_tcp_response_decoder.sv]
// Top level of the Modbus TCP response decoder.
// Takes one response frame byte per transfer (tlast on the final byte) and
// returns data items as the bytes arrive plus one status item after the last
// byte; when the status is not ok the consumer drops that frame's data items.
// Each byte is decoded while it sits in the input register and its results
// enter a four-entry result FIFO at the next edge, so one byte is accepted
// every cycle; a byte that yields both a data item and the status item needs
// two output transfers, and the input stalls while the FIFO has fewer than two
// free entries. The first result of a byte passes the input register and then
// the result FIFO before it can transfer.
module modbus_tcp_response_decoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [7:0] rx_byte, [18:8] expected_quantity, [23:19] zero
  input  logic [mtrd_pkg::InDataW-1:0]    s_axis_tdata_i,
  input  logic                            s_axis_tlast_i,  // frame_last
  input  logic                            s_axis_tuser_i,  // decode_mode
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [15:0] data_value, [20:16] valid_bits, [23:21] status,
  // [39:24] txn_id, [47:40] unit_id, [55:48] exception_code,
  // [56] exception_present, [63:57] zero
  output logic [mtrd_pkg::OutDataW-1:0]   m_axis_tdata_o,
  output logic                            m_axis_tlast_o,  // last_of_run
  output logic                            m_axis_tuser_o   // item_kind
);
  import mtrd_pkg::*;

  logic            in_valid_q;
  logic [ByteW-1:0] byte_q;
  logic            last_q;
  logic            mode_q;
  logic [QtyW-1:0] qty_q;
  logic            advance;
  logic            room2;
  mtrd_push_t      push;
  mtrd_result_t    res;

  assign advance         = in_valid_q && room2;
  assign s_axis_tready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      byte_q <= s_axis_tdata_i[ByteW-1:0];
      qty_q  <= s_axis_tdata_i[ByteW+QtyW-1:ByteW];
      last_q <= s_axis_tlast_i;
      mode_q <= s_axis_tuser_i;
    end
  end

  mtrd_parser u_parser (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .valid_i             (advance),
    .rx_byte_i           (byte_q),
    .frame_last_i        (last_q),
    .decode_mode_i       (mode_q),
    .expected_quantity_i (qty_q),
    .push_o              (push)
  );

  mtrd_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room2_o (room2),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (res)
  );

  // Pack the result onto the output stream
  assign m_axis_tdata_o = {7'b0, res.exception_present, res.exception_code, res.unit_id,
                           res.txn_id, res.status, res.valid_bits,
                           res.data_value};
  assign m_axis_tlast_o = res.last_of_run;
  assign m_axis_tuser_o = res.item_kind;

  // A held byte with no room in the FIFO stalls the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !room2 |=> in_valid_q && $stable(byte_q) && $stable(last_q))
    else $error("held input byte lost under back-pressure");

endmodule
